>>> hw/rtl/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types and constants of the polyphonic pulse tone generator.
// ----------------------------------------------------------------------------
package ppt_pkg;

  localparam int unsigned FREQ_W   = 16;
  localparam int unsigned DUTY_W   = 10;
  localparam int unsigned AMP_W    = 8;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 2;
  // period times duty, also the dividend width of the period divider
  localparam int unsigned PROD_W   = FREQ_W + DUTY_W;
  localparam int unsigned DUTY_MAX = 1000;

  // divide by 1000 as multiply by ceil(2^36 / 1000) and shift right by 36;
  // exact for any product below 2^PROD_W
  localparam int unsigned DUTY_RECIP_W     = 27;
  localparam int unsigned DUTY_RECIP_SHIFT = 36;
  localparam logic [DUTY_RECIP_W-1:0] DUTY_RECIP = 27'd68719477;

  localparam logic [CFG_IDX_W-1:0] CFG_DUTY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP  = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_PLAYING     = 2'd1,
    ST_FULL        = 2'd2,
    ST_NOT_PLAYING = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_DIV_PER,
    S_PER_WAIT,
    S_MUL,
    S_DIV_HIGH,
    S_HIGH_WAIT,
    S_WRITE,
    S_RESP
  } ctl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic div_per;
    logic cap_period;
    logic mul;
    logic div_high;
    logic cap_high;
    logic write;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic need_div;
    logic div_done;
  } sts_t;

endpackage

>>> hw/rtl/ppt_div.sv
// ----------------------------------------------------------------------------
// ppt_div
// Restoring divider, one quotient bit per cycle, used for the voice period
// calculation.
// ----------------------------------------------------------------------------
module ppt_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ppt_pkg::PROD_W-1:0]  dividend_i,
  input  logic [ppt_pkg::FREQ_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [ppt_pkg::PROD_W-1:0]  quotient_o
);
  import ppt_pkg::*;

  localparam int unsigned CNT_W = $clog2(PROD_W);

  logic               busy_q;
  logic               done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [FREQ_W-1:0]  rem_q;
  logic [FREQ_W-1:0]  dvs_q;
  logic [PROD_W-1:0]  quo_q;

  logic [FREQ_W:0]    shifted;
  logic [FREQ_W:0]    diff;
  logic               ge;

  assign shifted = {rem_q, quo_q[PROD_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(PROD_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[FREQ_W-1:0] : shifted[FREQ_W-1:0];
      quo_q <= {quo_q[PROD_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef ASSERT_OFF
  a_no_early_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> !done_o) else $error("divider done right after start");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("divider done longer than one cycle");
  a_nonzero_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> divisor_i != '0) else $error("divider started with zero divisor");
`endif

endmodule

>>> hw/rtl/ppt_dp.sv
// ----------------------------------------------------------------------------
// ppt_dp
// Datapath: voice bank, config registers, voice scan, period and high time
// arithmetic, result register.
// ----------------------------------------------------------------------------
module ppt_dp #(
  parameter int unsigned NUM_VOICES     = 8,
  parameter int unsigned SAMPLE_RATE_HZ = 44100
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ppt_pkg::cmd_t                 cmd_i,
  output ppt_pkg::sts_t                 sts_o,
  input  logic [ppt_pkg::OP_W-1:0]      operation_i,
  input  logic [ppt_pkg::FREQ_W-1:0]    frequency_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ppt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ppt_pkg::DUTY_W-1:0]    cfg_data_i,
  output logic                          is_sample_o,
  output logic [ppt_pkg::AMP_W-1:0]     sample_o,
  output logic [ppt_pkg::STATUS_W-1:0]  status_o
);
  import ppt_pkg::*;

  localparam int unsigned VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  // config
  logic [DUTY_W-1:0]   duty_q;
  logic [AMP_W-1:0]    amp_q;
  logic [DUTY_W-1:0]   duty_sat;

  // current item
  logic [OP_W-1:0]     op_q;
  logic [FREQ_W-1:0]   fin_q;
  logic [VW-1:0]       idx_q;
  logic                any_q;
  logic                match_q;
  logic                free_q;
  logic [VW-1:0]       slot_free_q;
  logic [VW-1:0]       slot_match_q;
  logic [FREQ_W-1:0]   period_q;
  logic [FREQ_W-1:0]   high_q;
  logic [PROD_W-1:0]   prod_q;
  logic [PROD_W+DUTY_RECIP_W-1:0] recip_q;

  // result
  logic                is_sample_q;
  logic [AMP_W-1:0]    sample_q;
  logic [STATUS_W-1:0] status_q;
  logic [STATUS_W-1:0] status_d;

  // voice bank
  logic [FREQ_W-1:0]   vf_q [NUM_VOICES];
  logic [FREQ_W-1:0]   vc_q [NUM_VOICES];
  logic [FREQ_W-1:0]   vp_q [NUM_VOICES];
  logic [FREQ_W-1:0]   vh_q [NUM_VOICES];
  logic                vl_q [NUM_VOICES];

  // scan of one voice
  logic [FREQ_W-1:0]   cur_f;
  logic                active;
  logic                hit;
  logic                at_end;
  logic [FREQ_W-1:0]   cnt_inc;
  logic [FREQ_W-1:0]   cnt_new;
  logic                lvl_new;
  logic                do_tick;
  logic                on_ok;

  // divider
  logic                div_start;
  logic [PROD_W-1:0]   div_dividend;
  logic [FREQ_W-1:0]   div_divisor;
  logic                div_done;
  logic [PROD_W-1:0]   div_quotient;

  assign cfg_ready_o = 1'b1;
  assign duty_sat = (duty_q > DUTY_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : duty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q <= DUTY_W'(500);
      amp_q  <= AMP_W'(127);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_DUTY) begin
        duty_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_AMP) begin
        amp_q <= cfg_data_i[AMP_W-1:0];
      end
    end
  end

  assign cur_f   = vf_q[idx_q];
  assign active  = cur_f != '0;
  assign hit     = active && (cur_f == fin_q);
  assign at_end  = vc_q[idx_q] == vp_q[idx_q];
  assign cnt_inc = vc_q[idx_q] + FREQ_W'(1);
  assign cnt_new = at_end ? '0 : cnt_inc;
  assign lvl_new = at_end ? vl_q[idx_q] : (cnt_inc < vh_q[idx_q]);
  assign do_tick = cmd_i.scan && (op_q == OP_TICK) && active;
  assign on_ok   = (fin_q != '0) && !match_q && free_q;

  always_comb begin
    status_d = ST_OK;
    case (op_q)
      OP_NOTE_ON: begin
        if (fin_q == '0) status_d = ST_FULL;
        else if (match_q) status_d = ST_PLAYING;
        else if (!free_q) status_d = ST_FULL;
        else status_d = ST_OK;
      end
      OP_NOTE_OFF: begin
        status_d = match_q ? ST_OK : ST_NOT_PLAYING;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  assign sts_o.scan_last = idx_q == VW'(NUM_VOICES - 1);
  assign sts_o.need_div  = (op_q == OP_NOTE_ON) && on_ok;
  assign sts_o.div_done  = div_done;

  // item registers and scan flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= '0;
      idx_q   <= '0;
      any_q   <= 1'b0;
      match_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (cmd_i.load) begin
      op_q    <= operation_i;
      idx_q   <= '0;
      any_q   <= 1'b0;
      match_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (cmd_i.scan) begin
      idx_q <= idx_q + 1'b1;
      if (hit) begin
        match_q <= 1'b1;
      end
      if (!active) begin
        free_q <= 1'b1;
      end
      if (do_tick && lvl_new) begin
        any_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fin_q <= frequency_i;
    end
    if (cmd_i.scan) begin
      // ascending scan: the last write wins, so the highest slot is kept
      if (hit) slot_match_q <= idx_q;
      if (!active) slot_free_q <= idx_q;
    end
    if (cmd_i.cap_period && div_done) begin
      period_q <= div_quotient[FREQ_W-1:0];
    end
    if (cmd_i.mul) begin
      prod_q <= period_q * duty_sat;
    end
    // high time: product divided by 1000 through the reciprocal
    if (cmd_i.div_high) begin
      recip_q <= prod_q * DUTY_RECIP;
    end
    if (cmd_i.cap_high) begin
      high_q <= recip_q[DUTY_RECIP_SHIFT +: FREQ_W];
    end
    if (cmd_i.decide) begin
      is_sample_q <= op_q == OP_TICK;
      sample_q    <= ((op_q == OP_TICK) && any_q) ? amp_q : '0;
      status_q    <= (op_q == OP_TICK) ? ST_OK : status_d;
    end
  end

  // voice bank with reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        vf_q[i] <= '0;
        vc_q[i] <= '0;
        vl_q[i] <= 1'b0;
      end
    end else begin
      if (do_tick) begin
        vc_q[idx_q] <= cnt_new;
        vl_q[idx_q] <= lvl_new;
      end
      if (cmd_i.decide && (op_q == OP_NOTE_OFF) && match_q) begin
        vf_q[slot_match_q] <= '0;
        vl_q[slot_match_q] <= 1'b0;
      end
      if (cmd_i.write) begin
        vf_q[slot_free_q] <= fin_q;
        vc_q[slot_free_q] <= '0;
        vl_q[slot_free_q] <= 1'b0;
      end
    end
  end

  // period and high time, written only at note-on
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      vp_q[slot_free_q] <= period_q;
      vh_q[slot_free_q] <= high_q;
    end
  end

  assign div_start    = cmd_i.div_per;
  assign div_dividend = PROD_W'(SAMPLE_RATE_HZ);
  assign div_divisor  = fin_q;

  ppt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  assign is_sample_o = is_sample_q;
  assign sample_o    = sample_q;
  assign status_o    = status_q;

endmodule

>>> hw/rtl/ppt_ctl.sv
// ----------------------------------------------------------------------------
// ppt_ctl
// Controller: sequences voice scan, divisions, bank write and result strobe.
// ----------------------------------------------------------------------------
module ppt_ctl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  output logic           done_o,
  output ppt_pkg::cmd_t  cmd_o,
  input  ppt_pkg::sts_t  sts_i
);
  import ppt_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:      if (start_i) state_d = S_SCAN;
      S_SCAN:      if (sts_i.scan_last) state_d = S_DECIDE;
      S_DECIDE:    state_d = sts_i.need_div ? S_DIV_PER : S_RESP;
      S_DIV_PER:   state_d = S_PER_WAIT;
      S_PER_WAIT:  if (sts_i.div_done) state_d = S_MUL;
      S_MUL:       state_d = S_DIV_HIGH;
      S_DIV_HIGH:  state_d = S_HIGH_WAIT;
      S_HIGH_WAIT: state_d = S_WRITE;
      S_WRITE:     state_d = S_RESP;
      S_RESP:      state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      S_SCAN:      cmd_o.scan       = 1'b1;
      S_DECIDE:    cmd_o.decide     = 1'b1;
      S_DIV_PER:   cmd_o.div_per    = 1'b1;
      S_PER_WAIT:  cmd_o.cap_period = 1'b1;
      S_MUL:       cmd_o.mul        = 1'b1;
      S_DIV_HIGH:  cmd_o.div_high   = 1'b1;
      S_HIGH_WAIT: cmd_o.cap_high   = 1'b1;
      S_WRITE:     cmd_o.write      = 1'b1;
      S_RESP:      done_o           = 1'b1;
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_resp_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RESP |=> state_q == S_IDLE) else $error("result strobe not single");
  a_start_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && state_q == S_IDLE) |=> state_q == S_SCAN) else $error("item not scanned");
  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_PER_WAIT || state_q == S_HIGH_WAIT))
    else $error("divider finished outside a wait state");
`endif

endmodule

>>> hw/rtl/polyphonic_pulse_tone_generator_core.sv
// ----------------------------------------------------------------------------
// polyphonic_pulse_tone_generator_core
// Bank of pulse voices with note-on/off handling and a mixed sample that is either the amplitude or zero.
// ----------------------------------------------------------------------------
// Usage:
//  - An item (operation_i, frequency_i) is taken when start_i is high and
//    busy_o is low. Operation 0 ticks the bank and yields a sample, 1 starts
//    a note, 2 stops one; each item gives exactly one result.
//  - The result sits on is_sample_o / sample_o / status_o for the single
//    cycle that done_o is high. There is no back-pressure: the receiver
//    must take it then.
//  - Sequence: the bank scan visits every voice in turn, then the item is
//    decided; a tick, note-off or refused note-on then strobes done_o. A note
//    that starts also passes through the divider start, a wait on the
//    bit-serial period divider, then the duty multiply, the reciprocal
//    multiply, the high-time capture and the bank write before done_o.
//    busy_o drops in the cycle after done_o, so the next item can follow
//    straight away.
//  - Config writes (index 0 duty in thousandths, 1 amplitude) are taken on
//    cfg_valid_i & cfg_ready_o and must only be issued while the core idles.
//  - Reset (rst_ni low, asynchronous) frees all voices, clears counters and
//    levels, and sets duty to 500 and amplitude to 127. No clearing pass.
// ----------------------------------------------------------------------------
module polyphonic_pulse_tone_generator_core #(
  parameter int unsigned NUM_VOICES     = 8,
  parameter int unsigned SAMPLE_RATE_HZ = 44100
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item channel
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [ppt_pkg::OP_W-1:0]      operation_i,
  input  logic [ppt_pkg::FREQ_W-1:0]    frequency_i,
  // result
  output logic                          done_o,
  output logic                          is_sample_o,
  output logic [ppt_pkg::AMP_W-1:0]     sample_o,
  output logic [ppt_pkg::STATUS_W-1:0]  status_o,
  // config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ppt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ppt_pkg::DUTY_W-1:0]    cfg_data_i
);
  import ppt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: only sequencing, no payload.
  ppt_ctl u_ctl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  // Datapath: voice bank, scan logic, divider and result register.
  ppt_dp #(
    .NUM_VOICES     (NUM_VOICES),
    .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .operation_i (operation_i),
    .frequency_i (frequency_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .is_sample_o (is_sample_o),
    .sample_o    (sample_o),
    .status_o    (status_o)
  );

endmodule
